### rtl/core/linear_key_value_table_macros.svh
// Assertion macros for the linear key/value table.
`ifndef LINEAR_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_KEY_VALUE_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LKVT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lkvt assertion failed");

`define LKVT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lkvt implication failed");

`else

`define LKVT_ASSERT(lbl, prop)

`define LKVT_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

### rtl/core/lkvt_pkg.sv
// ----------------------------------------------------------------------------
// lkvt_pkg
// Types and constants shared by the linear key/value table.
// ----------------------------------------------------------------------------
package lkvt_pkg;

  localparam int unsigned ENTRIES   = 1024;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SLOT_W    = 10;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [DATA_BITS-1:0] data_t;

  localparam idx_t LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_LOOKUP,
    CMD_REMOVE_KEY,
    CMD_REMOVE_SLOT
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_DUPLICATE,
    ST_FULL
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_PROBE,
    S_CHECK,
    S_WRITE,
    S_RESP
  } state_e;

  typedef struct packed {
    cmd_e  command;
    key_t  key;
    word_t payload;
    slot_t slot_handle;
  } lkvt_in_t;

  typedef struct packed {
    status_e status;
    slot_t   slot;
    word_t   data_out;
  } lkvt_out_t;

  typedef struct packed {
    logic valid;
    key_t key;
  } tag_t;

  typedef struct packed {
    logic  tag_en;
    logic  tag_we;
    logic  data_en;
    logic  data_we;
    idx_t  addr;
    tag_t  tag_wdata;
    data_t data_wdata;
  } mem_req_t;

  function automatic slot_t idx_to_slot(idx_t idx);
    return SLOT_W'(32'(idx));
  endfunction

endpackage

### rtl/core/lkvt_ram.sv
// ----------------------------------------------------------------------------
// lkvt_ram
// Single-port synchronous RAM, read-before-write, registered read data.
// ----------------------------------------------------------------------------
module lkvt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lkvt_ctrl.sv
// ----------------------------------------------------------------------------
// lkvt_ctrl
// Command sequencer: clearing pass, slot scan, probe and write-back.
// ----------------------------------------------------------------------------
module lkvt_ctrl import lkvt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lkvt_in_t  in_i,
  output mem_req_t  mem_req_o,
  input  tag_t      tag_rdata_i,
  input  data_t     data_rdata_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output lkvt_out_t res_o
);

  state_e    state_q, state_d;
  cmd_e      cmd_q, cmd_d;
  key_t      key_q, key_d;
  data_t     pay_q, pay_d;
  slot_t     handle_q, handle_d;
  idx_t      addr_q, addr_d;
  logic      chk_vld_q, chk_vld_d;
  idx_t      chk_idx_q, chk_idx_d;
  logic      free_vld_q, free_vld_d;
  idx_t      free_idx_q, free_idx_d;
  idx_t      wr_idx_q, wr_idx_d;
  logic      wr_set_q, wr_set_d;
  lkvt_out_t res_q, res_d;

  logic hit;
  logic free_now;

  assign hit      = chk_vld_q && tag_rdata_i.valid && (tag_rdata_i.key == key_q);
  assign free_now = chk_vld_q && !tag_rdata_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      addr_q     <= '0;
      chk_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      chk_vld_q  <= chk_vld_d;
      free_vld_q <= free_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    pay_q      <= pay_d;
    handle_q   <= handle_d;
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    wr_idx_q   <= wr_idx_d;
    wr_set_q   <= wr_set_d;
    res_q      <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    pay_d       = pay_q;
    handle_d    = handle_q;
    addr_d      = addr_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    free_vld_d  = free_vld_q;
    free_idx_d  = free_idx_q;
    wr_idx_d    = wr_idx_q;
    wr_set_d    = wr_set_q;
    res_d       = res_q;
    mem_req_o   = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_req_o.tag_en = 1'b1;
        mem_req_o.tag_we = 1'b1;
        mem_req_o.addr   = addr_q;
        if (addr_q == LAST_IDX) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        chk_vld_d  = 1'b0;
        free_vld_d = 1'b0;
        if (in_valid_i) begin
          cmd_d    = in_i.command;
          key_d    = in_i.key;
          pay_d    = DATA_BITS'(64'(in_i.payload));
          handle_d = in_i.slot_handle;
          addr_d   = '0;
          if (in_i.command == CMD_REMOVE_SLOT) begin
            if (32'(in_i.slot_handle) < ENTRIES) begin
              wr_idx_d = IDX_W'(32'(in_i.slot_handle));
              state_d  = S_PROBE;
            end else begin
              res_d.status   = ST_NOT_FOUND;
              res_d.slot     = in_i.slot_handle;
              res_d.data_out = '0;
              state_d        = S_RESP;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_PROBE: begin
        mem_req_o.tag_en = 1'b1;
        mem_req_o.addr   = wr_idx_q;
        state_d          = S_CHECK;
      end
      S_CHECK: begin
        res_d.slot     = handle_q;
        res_d.data_out = '0;
        if (tag_rdata_i.valid) begin
          res_d.status = ST_OK;
          wr_set_d     = 1'b0;
          state_d      = S_WRITE;
        end else begin
          res_d.status = ST_NOT_FOUND;
          state_d      = S_RESP;
        end
      end
      S_SCAN: begin
        mem_req_o.tag_en  = 1'b1;
        mem_req_o.data_en = 1'b1;
        mem_req_o.addr    = addr_q;
        chk_vld_d         = 1'b1;
        chk_idx_d         = addr_q;
        if (addr_q != LAST_IDX) begin
          addr_d = addr_q + 1'b1;
        end
        if (hit) begin
          wr_idx_d       = chk_idx_q;
          res_d.slot     = idx_to_slot(chk_idx_q);
          res_d.data_out = '0;
          unique case (cmd_q)
            CMD_INSERT: begin
              res_d.status = ST_DUPLICATE;
              state_d      = S_RESP;
            end
            CMD_LOOKUP: begin
              res_d.status   = ST_OK;
              res_d.data_out = WORD_W'(64'(data_rdata_i));
              state_d        = S_RESP;
            end
            CMD_REMOVE_KEY: begin
              res_d.status = ST_OK;
              wr_set_d     = 1'b0;
              state_d      = S_WRITE;
            end
            CMD_REMOVE_SLOT: begin
              res_d.status = ST_NOT_FOUND;
              state_d      = S_RESP;
            end
          endcase
        end else begin
          if (free_now && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_idx_d = chk_idx_q;
          end
          if (chk_vld_q && (chk_idx_q == LAST_IDX)) begin
            res_d.data_out = '0;
            if ((cmd_q == CMD_INSERT) && (free_vld_q || free_now)) begin
              wr_idx_d     = free_vld_q ? free_idx_q : chk_idx_q;
              wr_set_d     = 1'b1;
              res_d.status = ST_OK;
              res_d.slot   = idx_to_slot(free_vld_q ? free_idx_q : chk_idx_q);
              state_d      = S_WRITE;
            end else begin
              res_d.status = (cmd_q == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
              res_d.slot   = '0;
              state_d      = S_RESP;
            end
          end
        end
      end
      S_WRITE: begin
        mem_req_o.tag_en     = 1'b1;
        mem_req_o.tag_we     = 1'b1;
        mem_req_o.data_en    = wr_set_q;
        mem_req_o.data_we    = wr_set_q;
        mem_req_o.addr       = wr_idx_q;
        mem_req_o.tag_wdata  = '{valid: wr_set_q, key: key_q};
        mem_req_o.data_wdata = pay_q;
        state_d              = S_RESP;
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

### rtl/core/linear_key_value_table.sv
// ----------------------------------------------------------------------------
// linear_key_value_table
// Associative table searched slot by slot in two single-port RAMs.
// ----------------------------------------------------------------------------
// After reset the block walks every slot once to clear the valid marks and
// takes no transaction meanwhile. Insert, lookup and remove by key then walk
// the tag RAM one slot per cycle through its single port: a hit answers
// once its slot is checked, a miss after the last slot, and a successful
// insert or removal adds a write-back state. Remove by slot probes the
// named slot directly. One command is in flight at a time; the next is
// taken while the previous result waits in the output register.
`include "linear_key_value_table_macros.svh"

module linear_key_value_table import lkvt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lkvt_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lkvt_out_t out_o
);

  mem_req_t  mem_req;
  tag_t      tag_rdata;
  data_t     data_rdata;
  logic      res_valid;
  logic      res_ready;
  lkvt_out_t res;
  logic      out_valid_q, out_valid_d;
  lkvt_out_t out_q;

  lkvt_ram #(
    .WIDTH ($bits(tag_t)),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.tag_en),
    .we_i    (mem_req.tag_we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.tag_wdata),
    .rdata_o (tag_rdata)
  );

  lkvt_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.data_en),
    .we_i    (mem_req.data_we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.data_wdata),
    .rdata_o (data_rdata)
  );

  lkvt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .mem_req_o    (mem_req),
    .tag_rdata_i  (tag_rdata),
    .data_rdata_i (data_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `LKVT_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `LKVT_ASSERT(a_result_lands, (res_valid && res_ready) |=> out_valid_o)
  `LKVT_ASSERT_IMPL(a_full_slot_zero, out_valid_o && (out_o.status == ST_FULL), out_o.slot == '0)
  `LKVT_ASSERT_IMPL(a_data_only_on_ok, out_valid_o && (out_o.status != ST_OK), out_o.data_out == '0)

endmodule
